FILE: rtl/spp_pkg.sv
// shared widths and constants for the sample period pacer
package spp_pkg;

   localparam int NOW_W    = 32;
   localparam int PERIOD_W = 16;
   localparam int DELTA_W  = 26;
   localparam int SLEEP_W  = 16;
   localparam int MISSED_W = 10;
   localparam int RSP_DATA_W = 56;

   localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd2500;
   localparam logic [NOW_W-1:0]    SLEEP_MIN    = 32'd100;
   localparam logic [NOW_W-1:0]    DELTA_MAX    = 32'h03FF_FFFF;

   localparam logic OP_WAIT    = 1'b0;
   localparam logic OP_CONSUME = 1'b1;

endpackage

FILE: rtl/sample_period_pacer.sv
// top level: wait/consume sequencer, timebase state and result register
//
//  port group | dir | contents
//  req_       | in  | tuser op, tdata now_usec
//  rsp_       | out | tdata delta/sleep/missed, tuser already_pending
//  csr_       | in  | sample_period_usec write
//
// a beat counts its missed periods k (at most MAX_MISSED) with one subtract per
// period; no count is run when no time has passed or the period is zero, and a
// pending beat goes straight from the prep step to the result.
// req_tready is high only while the sequencer is idle, from the cycle after
// the result is loaded. a finished result waits in the output register; the
// commit step stalls until that register is free. reset is synchronous.
module sample_period_pacer #(
   parameter int MAX_MISSED = 1000
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // now_usec[31:0]
   input  logic [0:0]  req_tuser,   // op[0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,   // delta_usec[25:0], sleep_usec[41:26], missed_periods[51:42]
   output logic [0:0]  rsp_tuser,   // already_pending[0]
   input  logic        csr_we,
   input  logic [15:0] csr_wdata
);

   localparam int CNT_W = $clog2(MAX_MISSED + 1);
   localparam int KW    = (CNT_W > spp_pkg::MISSED_W) ? CNT_W : spp_pkg::MISSED_W;
   localparam logic [spp_pkg::PERIOD_W-1:0] MaxW = spp_pkg::PERIOD_W'(MAX_MISSED);

   typedef enum logic [2:0] {
      S_IDLE,
      S_PREP,
      S_CALC,
      S_DIV,
      S_FIN
   } state_type;

   state_type state_ff, state_in;

   logic [spp_pkg::PERIOD_W-1:0] period_ff;
   logic                         op_ff, op_in;
   logic [spp_pkg::NOW_W-1:0]    now_ff, now_in;
   logic [spp_pkg::NOW_W-1:0]    slot_ff, slot_in;
   logic [spp_pkg::DELTA_W-1:0]  delta_ff, delta_in;
   logic                         pending_ff, pending_in;
   logic                         skip_ff, skip_in;
   logic [CNT_W-1:0]             k_ff, k_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [spp_pkg::RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic                         rsp_user_ff, rsp_user_in;

   logic                         div_start;
   logic                         div_done;
   logic [CNT_W-1:0]             div_q;

   logic [spp_pkg::NOW_W-1:0]    diff;
   logic [spp_pkg::NOW_W-1:0]    next_slot;
   logic [spp_pkg::NOW_W-1:0]    slack_usec;
   logic [spp_pkg::NOW_W-1:0]    cap_prod;
   logic [spp_pkg::DELTA_W-1:0]  cap_delta;
   logic [spp_pkg::DELTA_W-1:0]  diff_delta;
   logic [spp_pkg::SLEEP_W-1:0]  sleep_val;
   logic [KW-1:0]                k_wide;
   logic [spp_pkg::MISSED_W-1:0] missed_val;
   logic                         out_free;

   assign diff       = now_ff - slot_ff;
   assign next_slot  = slot_ff + spp_pkg::NOW_W'(period_ff);
   assign slack_usec = next_slot - now_ff;
   assign cap_prod  = spp_pkg::NOW_W'(MaxW) * spp_pkg::NOW_W'(period_ff);
   assign cap_delta = (cap_prod > spp_pkg::DELTA_MAX) ? spp_pkg::DELTA_MAX[spp_pkg::DELTA_W-1:0]
                                                      : cap_prod[spp_pkg::DELTA_W-1:0];
   assign diff_delta = (diff > spp_pkg::DELTA_MAX) ? spp_pkg::DELTA_MAX[spp_pkg::DELTA_W-1:0]
                                                   : diff[spp_pkg::DELTA_W-1:0];
   assign sleep_val = (slack_usec > spp_pkg::SLEEP_MIN &&
                       slack_usec <= spp_pkg::NOW_W'(period_ff))
                      ? slack_usec[spp_pkg::SLEEP_W-1:0] : '0;
   assign k_wide     = KW'(k_ff);
   assign missed_val = (k_wide > KW'(10'h3FF)) ? 10'h3FF : k_wide[spp_pkg::MISSED_W-1:0];
   assign out_free   = !rsp_valid_ff || rsp_tready;

   spp_div #(
      .MAX_MISSED (MAX_MISSED),
      .CNT_W      (CNT_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (diff - spp_pkg::NOW_W'(1)),
      .divisor  (period_ff),
      .done     (div_done),
      .quotient (div_q)
   );

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      now_in       = now_ff;
      slot_in      = slot_ff;
      delta_in     = delta_ff;
      pending_in   = pending_ff;
      skip_in      = skip_ff;
      k_in         = k_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      div_start    = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               op_in    = req_tuser[0];
               now_in   = req_tdata;
               state_in = S_PREP;
            end
         end
         S_PREP: begin
            skip_in = pending_ff;
            if (pending_ff) begin
               state_in = S_FIN;
            end else begin
               if (slot_ff == '0 && delta_ff == '0) begin
                  slot_in  = now_ff;
                  delta_in = spp_pkg::DELTA_W'(period_ff);
               end
               state_in = S_CALC;
            end
         end
         S_CALC: begin
            if (diff == '0) begin
               k_in     = '0;
               state_in = S_FIN;
            end else if (period_ff == '0) begin
               k_in     = CNT_W'(MAX_MISSED);
               state_in = S_FIN;
            end else begin
               div_start = 1'b1;
               state_in  = S_DIV;
            end
         end
         S_DIV: begin
            if (div_done) begin
               k_in     = div_q;
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (skip_ff) begin
                  rsp_data_in = '0;
                  rsp_user_in = 1'b1;
               end else begin
                  rsp_user_in = 1'b0;
                  if (k_ff == CNT_W'(MAX_MISSED)) begin
                     slot_in  = now_ff;
                     delta_in = cap_delta;
                     rsp_data_in = {4'b0, missed_val, 16'b0, cap_delta};
                  end else if (k_ff == '0) begin
                     slot_in  = next_slot;
                     delta_in = spp_pkg::DELTA_W'(period_ff);
                     rsp_data_in = {4'b0, missed_val, sleep_val,
                                    spp_pkg::DELTA_W'(period_ff)};
                  end else begin
                     slot_in  = now_ff;
                     delta_in = diff_delta;
                     rsp_data_in = {4'b0, missed_val, 16'b0, diff_delta};
                  end
               end
               pending_in = (op_ff != spp_pkg::OP_CONSUME);
               state_in   = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         period_ff    <= spp_pkg::PERIOD_RESET;
         slot_ff      <= '0;
         delta_ff     <= '0;
         pending_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         period_ff    <= csr_we ? csr_wdata : period_ff;
         slot_ff      <= slot_in;
         delta_ff     <= delta_in;
         pending_ff   <= pending_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff       <= op_in;
      now_ff      <= now_in;
      skip_ff     <= skip_in;
      k_ff        <= k_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign req_tready   = (state_ff == S_IDLE);
   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_data_ff;
   assign rsp_tuser[0] = rsp_user_ff;

endmodule

FILE: rtl/spp_div.sv
// repeated-subtract period counter, one period per cycle, capped at the limit
module spp_div #(
   parameter int MAX_MISSED = 1000,
   parameter int CNT_W      = 10
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [spp_pkg::NOW_W-1:0]      dividend,
   input  logic [spp_pkg::PERIOD_W-1:0]   divisor,
   output logic                           done,
   output logic [CNT_W-1:0]               quotient
);

   logic [spp_pkg::NOW_W-1:0] rem_ff, rem_in;
   logic [CNT_W-1:0]          cnt_ff, cnt_in;
   logic                      busy_ff, busy_in;
   logic                      done_ff, done_in;
   logic                      step;

   assign step = (rem_ff >= spp_pkg::NOW_W'(divisor)) && (cnt_ff != CNT_W'(MAX_MISSED));

   always_comb begin
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = dividend;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (step) begin
            rem_in = rem_ff - spp_pkg::NOW_W'(divisor);
            cnt_in = cnt_ff + CNT_W'(1);
         end else begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
   end

   assign done     = done_ff;
   assign quotient = cnt_ff;

endmodule

FILE: verif/tb_top.sv
// self-checking testbench for sample_period_pacer: slot predictor, stream driver and monitor
module tb_top;

   localparam logic [spp_pkg::NOW_W-1:0] MISSED_CAP = 32'd1000;
   localparam int QUIET_LIMIT = 20000;
   localparam int DRAIN_CYCLES = 1100;
   localparam int PHASES = 7;
   localparam int ITEMS_PER_PHASE = 80;

   typedef struct packed {
      logic                      op;
      logic [spp_pkg::NOW_W-1:0] now;
   } slot_request_type;

   typedef struct packed {
      logic [spp_pkg::DELTA_W-1:0]  delta;
      logic [spp_pkg::SLEEP_W-1:0]  sleep;
      logic [spp_pkg::MISSED_W-1:0] missed;
      logic                         pending;
   } pace_result_type;

   typedef struct {
      logic [spp_pkg::NOW_W-1:0]    slot;
      logic [spp_pkg::DELTA_W-1:0]  last_delta;
      logic                         pending;
      logic [spp_pkg::PERIOD_W-1:0] period;
   } slot_state_type;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_tvalid = 1'b0;
   logic                           req_tready;
   logic [31:0]                    req_tdata = '0;
   logic [0:0]                     req_tuser = '0;
   logic                           rsp_tvalid;
   logic                           rsp_tready = 1'b0;
   logic [spp_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic [0:0]                     rsp_tuser;
   logic                           csr_we = 1'b0;
   logic [15:0]                    csr_wdata = '0;

   slot_request_type slot_requests[$];
   pace_result_type  paced_results[$];
   slot_state_type   plan_state;
   slot_state_type   track_state;
   int               send_gap_pct = 0;
   int               recv_stall_pct = 0;
   int               fail_count = 0;
   int               quiet_cycles = 0;

   sample_period_pacer u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   always #4 clock = ~clock;

   function automatic logic [spp_pkg::DELTA_W-1:0] clip_delta(input logic [63:0] v);
      return (v > 64'(spp_pkg::DELTA_MAX)) ? spp_pkg::DELTA_MAX[spp_pkg::DELTA_W-1:0]
                                           : v[spp_pkg::DELTA_W-1:0];
   endfunction

   function automatic pace_result_type advance_slot(inout slot_state_type st, input logic op,
                                                    input logic [spp_pkg::NOW_W-1:0] now);
      pace_result_type           r;
      logic [spp_pkg::NOW_W-1:0] diff;
      logic [spp_pkg::NOW_W-1:0] k;
      logic [spp_pkg::NOW_W-1:0] w;
      r = '0;
      if (st.pending) begin
         r.pending = 1'b1;
      end else begin
         // a request while slot and last delta are both zero seeds the timebase
         if (st.slot == 0 && st.last_delta == 0) begin
            st.slot = now;
            st.last_delta = clip_delta(64'(st.period));
         end
         diff = now - st.slot;
         if (diff == 0)
            k = '0;
         else if (st.period == 0)
            k = MISSED_CAP;
         else
            k = (diff - 32'd1) / 32'(st.period);
         if (k >= MISSED_CAP) begin
            k = MISSED_CAP;
            st.slot = now;
            st.last_delta = clip_delta(64'(MISSED_CAP) * 64'(st.period));
         end else if (k == 0) begin
            st.slot = st.slot + 32'(st.period);
            w = st.slot - now;
            if (w > spp_pkg::SLEEP_MIN && w <= 32'(st.period))
               r.sleep = w[spp_pkg::SLEEP_W-1:0];
            st.last_delta = clip_delta(64'(st.period));
         end else begin
            st.last_delta = clip_delta(64'(diff));
            st.slot = now;
         end
         st.pending = 1'b1;
         r.delta = st.last_delta;
         r.missed = k[spp_pkg::MISSED_W-1:0];
      end
      if (op == spp_pkg::OP_CONSUME) st.pending = 1'b0;
      return r;
   endfunction

   task automatic queue_request(input logic op, input logic [spp_pkg::NOW_W-1:0] now);
      void'(advance_slot(plan_state, op, now));
      slot_requests.push_back({op, now});
   endtask

   task automatic queue_random_request();
      int                        pick;
      logic                      op;
      logic [spp_pkg::NOW_W-1:0] p;
      logic [spp_pkg::NOW_W-1:0] pmax;
      logic [spp_pkg::NOW_W-1:0] now;
      p = 32'(plan_state.period);
      pmax = (p == 0) ? 32'd1 : p;
      pick = $urandom_range(0, 99);
      if (pick < 55)
         now = plan_state.slot + $urandom_range(1, pmax);
      else if (pick < 75)
         now = plan_state.slot + p * $urandom_range(1, 5) + $urandom_range(1, pmax);
      else if (pick < 80)
         now = plan_state.slot;
      else if (pick < 84)
         now = plan_state.slot - $urandom_range(1, 200);
      else if (pick < 88)
         now = plan_state.slot + p * $urandom_range(997, 1001) + $urandom_range(0, 1);
      else if (pick < 92)
         now = $urandom;
      else
         now = plan_state.slot + $urandom_range(0, 3 * pmax);
      if (plan_state.pending)
         op = ($urandom_range(0, 99) < 80) ? spp_pkg::OP_CONSUME : spp_pkg::OP_WAIT;
      else
         op = ($urandom_range(0, 1) == 1) ? spp_pkg::OP_CONSUME : spp_pkg::OP_WAIT;
      queue_request(op, now);
   endtask

   always @(posedge clock) begin : driver
      slot_request_type beat;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (slot_requests.size() != 0 && $urandom_range(0, 99) >= send_gap_pct) begin
            beat = slot_requests.pop_front();
            req_tvalid <= 1'b1;
            req_tdata <= beat.now;
            req_tuser <= beat.op;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin : monitor
      pace_result_type want;
      pace_result_type got;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
         if (rsp_tvalid && rsp_tready) begin
            got.delta = rsp_tdata[25:0];
            got.sleep = rsp_tdata[41:26];
            got.missed = rsp_tdata[51:42];
            got.pending = rsp_tuser[0];
            if (paced_results.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("unexpected beat: delta %0d sleep %0d missed %0d pending %0b",
                           got.delta, got.sleep, got.missed, got.pending);
            end else begin
               want = paced_results.pop_front();
               if (got != want) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("mismatch: exp delta %0d sleep %0d missed %0d pending %0b, %s",
                              want.delta, want.sleep, want.missed, want.pending,
                              $sformatf("got delta %0d sleep %0d missed %0d pending %0b",
                                        got.delta, got.sleep, got.missed, got.pending));
               end
            end
         end
         if (req_tvalid && req_tready)
            paced_results.push_back(advance_slot(track_state, req_tuser[0], req_tdata));
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("sample_period_pacer test failed");
            $finish;
         end
      end
   end

   initial begin
      logic [spp_pkg::PERIOD_W-1:0] period;
      plan_state = '{slot: '0, last_delta: '0, pending: 1'b0, period: spp_pkg::PERIOD_RESET};
      track_state = plan_state;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (int ph = 0; ph < PHASES; ph++) begin
         if (ph != 0) begin
            while (slot_requests.size() != 0 || req_tvalid || paced_results.size() != 0)
               @(negedge clock);
            case (ph)
               1: period = 16'd1;
               2: period = 16'hFFFF;
               3: period = 16'd0;
               4: period = 16'($urandom_range(101, 5000));
               5: period = 16'd100;
               default: period = 16'($urandom);
            endcase
            repeat (16) @(posedge clock);
            csr_we <= 1'b1;
            csr_wdata <= period;
            @(posedge clock);
            csr_we <= 1'b0;
            plan_state.period = period;
            track_state.period = period;
            @(negedge clock);
         end
         case (ph % 4)
            0: begin send_gap_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_gap_pct = 75; recv_stall_pct = 0;  end
            2: begin send_gap_pct = 0;  recv_stall_pct = 75; end
            default: begin send_gap_pct = 19; recv_stall_pct = 19; end
         endcase

         if (ph == 0) begin
            queue_request(spp_pkg::OP_WAIT, 32'd0);
            queue_request(spp_pkg::OP_WAIT, 32'd5);
            queue_request(spp_pkg::OP_CONSUME, 32'd10);
            // sleep of exactly the minimum is dropped, one above is kept
            queue_request(spp_pkg::OP_CONSUME, plan_state.slot + plan_state.period - 100);
            queue_request(spp_pkg::OP_CONSUME, plan_state.slot + plan_state.period - 101);
            queue_request(spp_pkg::OP_CONSUME, plan_state.slot + plan_state.period);
            queue_request(spp_pkg::OP_CONSUME, plan_state.slot + plan_state.period + 1);
            queue_request(spp_pkg::OP_CONSUME, plan_state.slot + plan_state.period * 999 + 1);
            queue_request(spp_pkg::OP_CONSUME, plan_state.slot + plan_state.period * 1000 + 1);
            queue_request(spp_pkg::OP_CONSUME, plan_state.slot);
            queue_request(spp_pkg::OP_CONSUME, plan_state.slot - 1);
            queue_request(spp_pkg::OP_WAIT, 32'hFFFF_FFFF);
            queue_request(spp_pkg::OP_CONSUME, 32'hFFFF_FFFF);
            queue_request(spp_pkg::OP_CONSUME, plan_state.slot + 1);
            queue_request(spp_pkg::OP_WAIT, 32'hAAAA_5555);
            queue_request(spp_pkg::OP_CONSUME, 32'h5555_AAAA);
         end else if (period == 0) begin
            // zero period: pull the slot back to zero, then reseed
            queue_request(spp_pkg::OP_CONSUME, 32'd0);
            queue_request(spp_pkg::OP_CONSUME, 32'd12345);
            queue_request(spp_pkg::OP_CONSUME, plan_state.slot);
         end

         for (int i = 0; i < ITEMS_PER_PHASE; i++)
            queue_random_request();
      end

      while (slot_requests.size() != 0 || req_tvalid || paced_results.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && paced_results.size() == 0)
         $display("sample_period_pacer test passed");
      else
         $display("sample_period_pacer test failed");
      $finish;
   end

endmodule
